// ----- rtl/writ_pkg.sv -----
// Shared types, codes and constants of the work/rest interval timer.
package writ_pkg;

  // Field widths of the item, result and configuration beats
  localparam int OPCODE_W   = 3;
  localparam int MIN_W      = 7;
  localparam int OUT_TIME_W = 16;
  localparam int IDX_W      = 8;
  localparam int PHASE_W    = 2;
  localparam int MODE_W     = 2;
  localparam int CYCLES_W   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_TIME_W = 16;

  // |minutes| * 60 stays below 4096 for a 7-bit signed minute count
  localparam int MAG_W = 12;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_START  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_TOGGLE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SKIP   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd5;

  // Phases
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WORK = 2'd1;
  localparam logic [PHASE_W-1:0] PH_REST = 2'd2;

  // Modes
  localparam logic [MODE_W-1:0] MODE_OPEN     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INTERVAL = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE_SEL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_SECONDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORK_SECONDS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REST_SECONDS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AUTOSTART      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SECONDS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SECONDS    = 3'd7;

  // Register reset values
  localparam logic [MODE_W-1:0]     RST_MODE_SEL       = MODE_SINGLE;
  localparam logic [CFG_TIME_W-1:0] RST_SINGLE_SECONDS = 16'd1500;
  localparam logic [CFG_TIME_W-1:0] RST_WORK_SECONDS   = 16'd1500;
  localparam logic [CFG_TIME_W-1:0] RST_REST_SECONDS   = 16'd300;
  localparam logic [CYCLES_W-1:0]   RST_CYCLE_COUNT    = 7'd4;
  localparam logic                  RST_AUTOSTART      = 1'b0;
  localparam logic [CFG_TIME_W-1:0] RST_MIN_SECONDS    = 16'd60;
  localparam logic [CFG_TIME_W-1:0] RST_MAX_SECONDS    = 16'd35940;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_COMMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch the accepted item, seed the remainder unit
    logic div_step;  // one restoring-division step
    logic commit;    // update timer state, load result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_add;    // latched item is an add-minutes command
  } dp_status_t;

endpackage

// ----- rtl/writ_req_if.sv -----
// Item channel: one command beat per opcode.
interface writ_req_if;
  logic                                valid;
  logic                                ready;
  logic [writ_pkg::OPCODE_W-1:0]       opcode;
  logic signed [writ_pkg::MIN_W-1:0]   add_minutes;

  modport source (output valid, output opcode, output add_minutes, input ready);
  modport sink   (input valid, input opcode, input add_minutes, output ready);
endinterface

// ----- rtl/writ_rsp_if.sv -----
// Result channel: timer state after each item plus event flags.
interface writ_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [writ_pkg::PHASE_W-1:0]      phase;
  logic [writ_pkg::MODE_W-1:0]       active_mode_out;
  logic                              is_running;
  logic [writ_pkg::OUT_TIME_W-1:0]   remaining_seconds;
  logic [writ_pkg::OUT_TIME_W-1:0]   elapsed_seconds;
  logic [writ_pkg::IDX_W-1:0]        phase_index;
  logic                              phase_changed;
  logic                              interval_ended;
  logic                              ended_by_force;
  logic                              pause_changed;
  logic                              mode_changed;
  logic                              tick_event;

  modport source (
    output valid, output phase, output active_mode_out, output is_running,
    output remaining_seconds, output elapsed_seconds, output phase_index,
    output phase_changed, output interval_ended, output ended_by_force,
    output pause_changed, output mode_changed, output tick_event,
    input ready
  );
  modport sink (
    input valid, input phase, input active_mode_out, input is_running,
    input remaining_seconds, input elapsed_seconds, input phase_index,
    input phase_changed, input interval_ended, input ended_by_force,
    input pause_changed, input mode_changed, input tick_event,
    output ready
  );
endinterface

// ----- rtl/writ_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface writ_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [writ_pkg::CFG_IDX_W-1:0]    index;
  logic [writ_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/writ_ctrl.sv -----
// Sequencer: accepts an item, runs the remainder unit, commits the result.
module writ_ctrl #(
  parameter int TIME_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  writ_pkg::dp_status_t  status,
  output writ_pkg::ctrl_cmd_t   cmd
);

  localparam int CNT_W = $clog2(TIME_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_WIDTH - 1);

  writ_pkg::ctrl_state_t state, state_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic                  out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= writ_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      writ_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = writ_pkg::S_DIV;
        end
      end
      writ_pkg::S_DIV: begin
        if (!status.op_add) begin
          state_next = writ_pkg::S_COMMIT;
        end else begin
          cmd.div_step = 1'b1;
          if (cnt == CNT_LAST) begin
            cnt_next   = '0;
            state_next = writ_pkg::S_COMMIT;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      writ_pkg::S_COMMIT: begin
        // result register free or being drained this cycle
        if (!out_valid || out_ready) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = writ_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = writ_pkg::S_IDLE;
      end
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_accept_seeds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == writ_pkg::S_DIV && cnt == '0))
    else $error("accepted beat did not start a fresh pass");

  a_cnt_in_div: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> (state == writ_pkg::S_DIV))
    else $error("step counter live outside division");

  a_skip_div: assert property (@(posedge clk) disable iff (rst)
    (state == writ_pkg::S_DIV && !status.op_add) |=> (state == writ_pkg::S_COMMIT))
    else $error("non-add item stuck in division");

endmodule

// ----- rtl/writ_dp.sv -----
// Datapath: config registers, timer state, remainder unit, next-state and result.
module writ_dp #(
  parameter int TIME_WIDTH             = 16,
  parameter int OPEN_TO_SINGLE_MINUTES = 25
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  writ_pkg::ctrl_cmd_t                   cmd,
  output writ_pkg::dp_status_t                  status,
  input  logic [writ_pkg::OPCODE_W-1:0]         opcode,
  input  logic signed [writ_pkg::MIN_W-1:0]     add_minutes,
  input  logic                                  cfg_we,
  input  logic [writ_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [writ_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [writ_pkg::PHASE_W-1:0]          phase,
  output logic [writ_pkg::MODE_W-1:0]           active_mode_out,
  output logic                                  is_running,
  output logic [writ_pkg::OUT_TIME_W-1:0]       remaining_seconds,
  output logic [writ_pkg::OUT_TIME_W-1:0]       elapsed_seconds,
  output logic [writ_pkg::IDX_W-1:0]            phase_index,
  output logic                                  phase_changed,
  output logic                                  interval_ended,
  output logic                                  ended_by_force,
  output logic                                  pause_changed,
  output logic                                  mode_changed,
  output logic                                  tick_event
);

  localparam int TW = TIME_WIDTH;
  // common width for comparing times against 16-bit config values
  localparam int CW = (TW > writ_pkg::CFG_TIME_W) ? TW : writ_pkg::CFG_TIME_W;
  // signed width for the add-minutes sum
  localparam int SW = CW + 2;
  localparam int OPEN_SECS = OPEN_TO_SINGLE_MINUTES * 60;
  localparam int TIME_MAX_I = (1 << TW) - 1;
  localparam logic [TW-1:0] TIME_MAX = '1;
  localparam logic [TW-1:0] OPEN_LEN =
    (OPEN_SECS > TIME_MAX_I) ? TW'(TIME_MAX_I) : TW'(OPEN_SECS);

  // ---- configuration registers
  logic [writ_pkg::MODE_W-1:0]     mode_sel;
  logic [writ_pkg::CFG_TIME_W-1:0] single_seconds, work_seconds, rest_seconds;
  logic [writ_pkg::CYCLES_W-1:0]   cycle_count;
  logic                            autostart;
  logic [writ_pkg::CFG_TIME_W-1:0] min_seconds, max_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sel       <= writ_pkg::RST_MODE_SEL;
      single_seconds <= writ_pkg::RST_SINGLE_SECONDS;
      work_seconds   <= writ_pkg::RST_WORK_SECONDS;
      rest_seconds   <= writ_pkg::RST_REST_SECONDS;
      cycle_count    <= writ_pkg::RST_CYCLE_COUNT;
      autostart      <= writ_pkg::RST_AUTOSTART;
      min_seconds    <= writ_pkg::RST_MIN_SECONDS;
      max_seconds    <= writ_pkg::RST_MAX_SECONDS;
    end else if (cfg_we) begin
      case (cfg_index)
        writ_pkg::REG_MODE_SEL:       mode_sel       <= cfg_data[writ_pkg::MODE_W-1:0];
        writ_pkg::REG_SINGLE_SECONDS: single_seconds <= cfg_data;
        writ_pkg::REG_WORK_SECONDS:   work_seconds   <= cfg_data;
        writ_pkg::REG_REST_SECONDS:   rest_seconds   <= cfg_data;
        writ_pkg::REG_CYCLE_COUNT:    cycle_count    <= cfg_data[writ_pkg::CYCLES_W-1:0];
        writ_pkg::REG_AUTOSTART:      autostart      <= cfg_data[0];
        writ_pkg::REG_MIN_SECONDS:    min_seconds    <= cfg_data;
        writ_pkg::REG_MAX_SECONDS:    max_seconds    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- timer state
  logic [writ_pkg::PHASE_W-1:0] phase_reg, phase_next;
  logic [writ_pkg::MODE_W-1:0]  active_mode, active_mode_next;
  logic                         running, running_next;
  logic [TW-1:0]                remaining_reg, remaining_next;
  logic [TW-1:0]                elapsed_reg, elapsed_next;
  logic [writ_pkg::IDX_W-1:0]   index_reg, index_next;
  logic ev_phase, ev_ended, ev_force, ev_pause, ev_mode, ev_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= writ_pkg::PH_IDLE;
      active_mode   <= writ_pkg::RST_MODE_SEL;
      running       <= 1'b0;
      remaining_reg <= '0;
      elapsed_reg   <= '0;
      index_reg     <= '0;
    end else if (cmd.commit) begin
      phase_reg     <= phase_next;
      active_mode   <= active_mode_next;
      running       <= running_next;
      remaining_reg <= remaining_next;
      elapsed_reg   <= elapsed_next;
      index_reg     <= index_next;
    end
  end

  // ---- latched item and bit-serial remainder unit
  logic [writ_pkg::OPCODE_W-1:0]     op_code;
  logic signed [writ_pkg::MIN_W-1:0] op_min;
  logic [writ_pkg::MAG_W-1:0]        op_mag;
  logic [writ_pkg::MIN_W-1:0]        in_abs;
  logic [writ_pkg::MAG_W:0]          in_mag;
  logic [TW-1:0]                     div_q;
  logic [writ_pkg::MAG_W-1:0]        div_r;
  logic [writ_pkg::MAG_W:0]          div_trial;

  // |m| * 60 = |m| * 64 - |m| * 4
  assign in_abs = add_minutes[writ_pkg::MIN_W-1] ? writ_pkg::MIN_W'(-add_minutes)
                                                 : add_minutes;
  assign in_mag = {in_abs, 6'b0} - {4'b0, in_abs, 2'b0};
  assign div_trial = {div_r, div_q[TW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_code <= opcode;
      op_min  <= add_minutes;
      op_mag  <= in_mag[writ_pkg::MAG_W-1:0];
      div_q   <= remaining_reg;
      div_r   <= '0;
    end else if (cmd.div_step) begin
      div_q <= div_q << 1;
      if (div_trial >= {1'b0, op_mag}) begin
        div_r <= writ_pkg::MAG_W'(div_trial - {1'b0, op_mag});
      end else begin
        div_r <= div_trial[writ_pkg::MAG_W-1:0];
      end
    end
  end

  assign status.op_add = (op_code == writ_pkg::OP_ADD);

  // ---- helpers
  function automatic logic [TW-1:0] sat_cfg(input logic [writ_pkg::CFG_TIME_W-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve > CW'(TIME_MAX)) begin
      sat_cfg = TIME_MAX;
    end else begin
      sat_cfg = ve[TW-1:0];
    end
  endfunction

  function automatic logic [writ_pkg::OUT_TIME_W-1:0] fit_out(input logic [TW-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    fit_out = ve[writ_pkg::OUT_TIME_W-1:0];
  endfunction

  // ---- add-minutes arithmetic
  logic                 mins_pos, mins_neg;
  logic signed [SW-1:0] rem_s, mag_s, r_s, lo_s, hi_s, max_s;
  logic signed [SW-1:0] add_sum, add_lo, add_hi;
  logic [TW-1:0]        add_rem;
  logic                 add_floor_block;

  assign mins_neg = op_min[writ_pkg::MIN_W-1];
  assign mins_pos = !mins_neg && (op_min != '0);
  assign rem_s = $signed(SW'(remaining_reg));
  assign mag_s = $signed(SW'(op_mag));
  assign r_s   = $signed(SW'(div_r));
  assign lo_s  = $signed(SW'(min_seconds));
  assign hi_s  = $signed(SW'(max_seconds));
  assign max_s = $signed(SW'(TIME_MAX));
  assign add_floor_block = mins_neg && (rem_s < lo_s);

  // round toward the sign of the step, then clamp low, then high, then to the timer maximum
  always_comb begin
    if (mins_pos) begin
      add_sum = rem_s - r_s + mag_s;
    end else if (div_r != '0) begin
      add_sum = rem_s - r_s;
    end else begin
      add_sum = rem_s - mag_s;
    end
    add_lo = (add_sum < lo_s) ? lo_s : add_sum;
    add_hi = (add_lo > hi_s) ? hi_s : add_lo;
    add_rem = (add_hi > max_s) ? TIME_MAX : add_hi[TW-1:0];
  end

  // ---- phase advance
  logic                          adv_en, adv_forced;
  logic [writ_pkg::CYCLES_W-1:0] cycles_eff;
  logic [writ_pkg::IDX_W-1:0]    adv_limit, adv_idx;
  logic [writ_pkg::PHASE_W-1:0]  adv_phase;
  logic [TW-1:0]                 adv_len;

  assign cycles_eff = (cycle_count == '0) ? writ_pkg::CYCLES_W'(1) : cycle_count;
  assign adv_limit  = {cycles_eff, 1'b0} - 1'b1;
  assign adv_forced = (op_code != writ_pkg::OP_TICK);

  always_comb begin
    phase_next       = phase_reg;
    active_mode_next = active_mode;
    running_next     = running;
    remaining_next   = remaining_reg;
    elapsed_next     = elapsed_reg;
    index_next       = index_reg;
    ev_phase = 1'b0;
    ev_ended = 1'b0;
    ev_force = 1'b0;
    ev_pause = 1'b0;
    ev_mode  = 1'b0;
    ev_tick  = 1'b0;
    adv_en    = 1'b0;
    adv_idx   = '0;
    adv_phase = writ_pkg::PH_IDLE;
    adv_len   = '0;

    case (op_code)
      writ_pkg::OP_TICK: begin
        if (running && phase_reg != writ_pkg::PH_IDLE && active_mode != writ_pkg::MODE_OPEN) begin
          if (remaining_reg != '0) begin
            remaining_next = remaining_reg - 1'b1;
            if (elapsed_reg != TIME_MAX) begin
              elapsed_next = elapsed_reg + 1'b1;
            end
            ev_tick = 1'b1;
          end else begin
            adv_en = 1'b1;
          end
        end
      end
      writ_pkg::OP_START: begin
        ev_mode = 1'b1;
        if (phase_reg == writ_pkg::PH_IDLE) begin
          // mode code three runs open-ended
          active_mode_next = (mode_sel > writ_pkg::MODE_INTERVAL) ? writ_pkg::MODE_OPEN
                                                                  : mode_sel;
          adv_en = 1'b1;
        end else begin
          running_next = 1'b1;
          ev_phase     = 1'b1;
          ev_tick      = 1'b1;
        end
      end
      writ_pkg::OP_STOP: begin
        running_next = 1'b0;
        phase_next   = writ_pkg::PH_IDLE;
      end
      writ_pkg::OP_TOGGLE: begin
        if (phase_reg != writ_pkg::PH_IDLE) begin
          running_next = !running;
          ev_pause     = 1'b1;
        end
      end
      writ_pkg::OP_SKIP: begin
        if (running) begin
          adv_en = 1'b1;
        end
      end
      writ_pkg::OP_ADD: begin
        if (running) begin
          if (active_mode == writ_pkg::MODE_OPEN) begin
            if (mins_pos) begin
              active_mode_next = writ_pkg::MODE_SINGLE;
              remaining_next   = OPEN_LEN;
              elapsed_next     = '0;
              ev_mode  = 1'b1;
              ev_phase = 1'b1;
              ev_tick  = 1'b1;
            end
          end else if (op_min != '0 && !add_floor_block) begin
            remaining_next = add_rem;
            ev_tick        = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (adv_en) begin
      if (phase_reg != writ_pkg::PH_IDLE && active_mode_next == writ_pkg::MODE_INTERVAL) begin
        adv_idx = index_reg + 1'b1;
      end else begin
        adv_idx = '0;
      end
      case (phase_reg)
        writ_pkg::PH_IDLE: adv_phase = writ_pkg::PH_WORK;
        writ_pkg::PH_WORK: begin
          adv_phase = (active_mode_next == writ_pkg::MODE_INTERVAL && adv_idx < adv_limit)
                      ? writ_pkg::PH_REST : writ_pkg::PH_IDLE;
        end
        default: begin
          adv_phase = (active_mode_next == writ_pkg::MODE_INTERVAL) ? writ_pkg::PH_WORK
                                                                    : writ_pkg::PH_IDLE;
        end
      endcase
      case (active_mode_next)
        writ_pkg::MODE_SINGLE:   adv_len = sat_cfg(single_seconds);
        writ_pkg::MODE_INTERVAL: begin
          adv_len = sat_cfg((adv_phase == writ_pkg::PH_REST) ? rest_seconds : work_seconds);
        end
        default: adv_len = '0;
      endcase

      index_next = adv_idx;
      phase_next = adv_phase;
      if (adv_phase != writ_pkg::PH_IDLE) begin
        elapsed_next   = '0;
        remaining_next = adv_len;
        if ((active_mode_next == writ_pkg::MODE_INTERVAL && autostart) || adv_forced) begin
          running_next = 1'b1;
          ev_phase     = 1'b1;
          ev_tick      = 1'b1;
        end else begin
          running_next = 1'b0;
          ev_ended     = 1'b1;
          ev_force     = adv_forced;
        end
      end else begin
        running_next = 1'b0;
        ev_phase     = 1'b1;
        ev_ended     = 1'b1;
        ev_force     = adv_forced;
      end
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      phase             <= phase_next;
      active_mode_out   <= active_mode_next;
      is_running        <= running_next;
      remaining_seconds <= fit_out(remaining_next);
      elapsed_seconds   <= fit_out(elapsed_next);
      phase_index       <= index_next;
      phase_changed     <= ev_phase;
      interval_ended    <= ev_ended;
      ended_by_force    <= ev_force;
      pause_changed     <= ev_pause;
      mode_changed      <= ev_mode;
      tick_event        <= ev_tick;
    end
  end

endmodule

// ----- rtl/work_rest_interval_timer_unit.sv -----
// Top level of the work/rest interval timer: channels, sequencer and datapath.
// Flow: an item is accepted in idle and latched; a non-add item leaves the division
//   state at once, an add-minutes item runs the restoring remainder unit there, one
//   dividend bit per cycle; the result beat is registered at commit, which waits while
//   the result register is full and not drained. No new item is taken until idle again.
// Reset (synchronous, rst high): config and timer state registers take their reset
//   values, timer idle, no result pending. Config writes are taken in every cycle.
module work_rest_interval_timer_unit #(
  parameter int TIME_WIDTH             = 16,
  parameter int OPEN_TO_SINGLE_MINUTES = 25
) (
  input logic      clk,
  input logic      rst,
  writ_req_if.sink   req,
  writ_rsp_if.source rsp,
  writ_cfg_if.sink   cfg
);

  writ_pkg::ctrl_cmd_t  cmd;
  writ_pkg::dp_status_t status;

  // Config registers live in flops and are always writable.
  assign cfg.ready = 1'b1;

  // Sequencer: idle -> division (steps for add-minutes only) -> commit into the
  // result register once it is free.
  writ_ctrl #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: holds config, timer state, remainder unit and result beat.
  writ_dp #(
    .TIME_WIDTH             (TIME_WIDTH),
    .OPEN_TO_SINGLE_MINUTES (OPEN_TO_SINGLE_MINUTES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .opcode            (req.opcode),
    .add_minutes       (req.add_minutes),
    .cfg_we            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .phase             (rsp.phase),
    .active_mode_out   (rsp.active_mode_out),
    .is_running        (rsp.is_running),
    .remaining_seconds (rsp.remaining_seconds),
    .elapsed_seconds   (rsp.elapsed_seconds),
    .phase_index       (rsp.phase_index),
    .phase_changed     (rsp.phase_changed),
    .interval_ended    (rsp.interval_ended),
    .ended_by_force    (rsp.ended_by_force),
    .pause_changed     (rsp.pause_changed),
    .mode_changed      (rsp.mode_changed),
    .tick_event        (rsp.tick_event)
  );

endmodule
